### hw/rtl/assert_macros.svh
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, muted while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/sobth_pkg.sv
package sobth_pkg;

  localparam int SOBTH_MAX_WIDTH = 1024;

  localparam int THR_W   = 9;
  localparam int RW_W    = 11;
  localparam int CFG_W   = 11;
  localparam int GRAD_W  = 9;
  localparam int MAG_W   = 9;
  localparam int SUM_W   = 17;
  localparam int ROOT_W  = 10;

  localparam logic [THR_W-1:0] THR_RESET = 9'd64;
  localparam logic [RW_W-1:0]  RW_RESET  = 11'd512;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_ROW_WIDTH   = 2'd1,
    REG_BORDER_MODE = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  // input kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // one window column: index 0 top, 1 centre, 2 bottom
  typedef logic [2:0][7:0] pix_col_t;

  typedef struct packed {
    logic [7:0]               edge_pixel;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [MAG_W-1:0]         magnitude;
  } grad_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX,
    ST_FMID,
    ST_FLEFT,
    ST_FRIGHT,
    ST_EMIT,
    ST_CALC,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    GS_IDLE,
    GS_SQ,
    GS_ROOT
  } grad_state_t;

endpackage

### hw/rtl/sobth_line_mem.sv
module sobth_line_mem #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [7:0]                   rd_old,
  output logic [7:0]                   rd_new,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [7:0]                   wr_old,
  input  logic [7:0]                   wr_new
);
  // older row and newer row, one byte per column each
  logic [7:0] old_mem [MAX_WIDTH];
  logic [7:0] new_mem [MAX_WIDTH];

  // synchronous read, registered output
  always_ff @(posedge clk) begin
    rd_old <= old_mem[rd_addr];
    rd_new <= new_mem[rd_addr];
  end

  // write back of both rows at one column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      old_mem[wr_addr] <= wr_old;
      new_mem[wr_addr] <= wr_new;
    end
  end
endmodule

### hw/rtl/sobth_grad.sv
module sobth_grad (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  sobth_pkg::pix_col_t       col_l,
  input  sobth_pkg::pix_col_t       col_m,
  input  sobth_pkg::pix_col_t       col_r,
  input  logic [8:0]                threshold,
  output logic                      done,
  output sobth_pkg::grad_res_t      res
);
  import sobth_pkg::*;

  grad_state_t state_r, state_nxt;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic [SUM_W-1:0]         sum_r;
  logic [ROOT_W-1:0]        root_r, root_nxt;
  logic [3:0]               idx_r;
  logic                     done_r;

  logic signed [11:0] sx, sy, sx_adj, sy_adj;
  logic signed [17:0] gx_sq, gy_sq;
  logic [ROOT_W-1:0]  trial;
  logic [19:0]        trial_sq;

  // sobel sums, divided by four toward zero
  always_comb begin
    sx = 12'($signed({4'b0, col_r[0]})) + 12'($signed({3'b0, col_r[1], 1'b0}))
       + 12'($signed({4'b0, col_r[2]})) - 12'($signed({4'b0, col_l[0]}))
       - 12'($signed({3'b0, col_l[1], 1'b0})) - 12'($signed({4'b0, col_l[2]}));
    sy = 12'($signed({4'b0, col_l[0]})) + 12'($signed({3'b0, col_m[0], 1'b0}))
       + 12'($signed({4'b0, col_r[0]})) - 12'($signed({4'b0, col_l[2]}))
       - 12'($signed({3'b0, col_m[2], 1'b0})) - 12'($signed({4'b0, col_r[2]}));
    sx_adj = sx + (sx[11] ? 12'sd3 : 12'sd0);
    sy_adj = sy + (sy[11] ? 12'sd3 : 12'sd0);
  end

  // squares and one root trial bit
  always_comb begin
    gx_sq    = gx_r * gx_r;
    gy_sq    = gy_r * gy_r;
    trial    = root_r | (ROOT_W'(1) << idx_r);
    trial_sq = trial * trial;
    root_nxt = (trial_sq <= {3'b0, sum_r}) ? trial : root_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      GS_IDLE: if (start) state_nxt = GS_SQ;
      GS_SQ:   state_nxt = GS_ROOT;
      GS_ROOT: if (idx_r == 4'd0) state_nxt = GS_IDLE;
      default: state_nxt = GS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == GS_ROOT) && (idx_r == 4'd0);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      GS_IDLE: begin
        gx_r <= GRAD_W'(sx_adj >>> 2);
        gy_r <= GRAD_W'(sy_adj >>> 2);
      end
      GS_SQ: begin
        sum_r  <= SUM_W'(gx_sq + gy_sq);
        root_r <= '0;
        idx_r  <= 4'd9;
      end
      GS_ROOT: begin
        root_r <= root_nxt;
        idx_r  <= idx_r - 4'd1;
      end
      default: ;
    endcase
  end

  // result view
  always_comb begin
    done           = done_r;
    res.grad_x     = gx_r;
    res.grad_y     = gy_r;
    res.magnitude  = root_r[MAG_W-1:0];
    res.edge_pixel = ({1'b0, root_r} > {2'b0, threshold}) ? 8'd0 : 8'd255;
  end
endmodule

### hw/rtl/sobel_edge_threshold.sv
// sobel edge detector with threshold
// in_*  : one request per pixel; in_tuser is the kind (0 pixel, 1 flush tick),
//         in_tdata[7:0] the gray value, raster order, row_width pixels a row
// out_* : edge_pixel, grad_x, grad_y and magnitude in out_tdata, out_tlast
//         marks the final result of the frame
// cfg_* : threshold, row_width and border_mode, written only while idle by
//         the user; the block itself does not enforce it.
// results lag one row; after the last pixel, row_width flush ticks give the
// last row. a pixel request passes the states PIX and EMIT, a flush tick FMID,
// FLEFT, FRIGHT and EMIT, then each result CALC and OUT; each result runs
// through the shared gradient unit whose root search takes one bit a cycle.
// the line store is one read and one write port, read one column a cycle.
// reset clears counters and window and sets registers to their defaults;
// the line store is not cleared. a stalled result holds out_tdata and keeps
// in_tready low until it is taken.
module sobel_edge_threshold #(
  parameter int MAX_WIDTH = sobth_pkg::SOBTH_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,  // pixel
  input  logic                       in_tuser,  // kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [39:0]                out_tdata, // edge_pixel, grad_x, grad_y, magnitude
  output logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [sobth_pkg::CFG_W-1:0] cfg_wdata
);
  import sobth_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  ctrl_state_t state_r, state_nxt;

  logic [THR_W-1:0] thr_r;
  logic [RW_W-1:0]  rw_r;
  logic             mode_r;

  logic [AW-1:0] col_r, flush_r;
  logic [1:0]    row_r;
  logic [7:0]    win_r [6];
  logic [7:0]    pix_r;
  logic          kind_r;
  pix_col_t      cl_r, cm_r, cn_r, cr_r;
  logic          pa_r, pb_r, last_r, flast_r;
  logic          out_valid_r;
  grad_res_t     out_res_r;
  logic          out_last_r;

  logic [AW-1:0] rd_addr, c_eff, wm1;
  logic [7:0]    rd_old, rd_new;
  logic          mem_we, in_acc, skip_flush;
  logic [31:0]   rw32;
  pix_col_t      nc, mc, lc, rc, sc;
  logic          c_last, k_last;
  logic          g_start, g_done;
  grad_res_t     g_res;
  pix_col_t      g_l, g_m, g_r;

  // effective row width minus one
  always_comb begin
    rw32 = 32'(rw_r);
    if (rw32 < 32'd2)              wm1 = AW'(1);
    else if (rw32 > 32'(MAX_WIDTH)) wm1 = AW'(MAX_WIDTH - 1);
    else                           wm1 = AW'(rw32 - 32'd1);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      rw_r   <= RW_RESET;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_THRESHOLD:   thr_r  <= cfg_wdata[THR_W-1:0];
        REG_ROW_WIDTH:   rw_r   <= cfg_wdata[RW_W-1:0];
        REG_BORDER_MODE: mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign skip_flush = (flush_r == '0) && ((col_r != '0) || (row_r == 2'd0));
  assign c_eff      = (flush_r != '0) ? '0 : col_r;
  assign c_last     = (col_r >= wm1);
  assign k_last     = (flush_r >= wm1);

  // stored column from the read data
  always_comb begin
    sc[1] = rd_new;
    sc[0] = (row_r == 2'd2) ? rd_old : rd_new;
    sc[2] = (mode_r && (row_r == 2'd2)) ? sc[0] : rd_new;
  end

  // window columns for a pixel request
  always_comb begin
    nc[1] = rd_new;
    nc[2] = pix_r;
    nc[0] = (row_r == 2'd2) ? rd_old : (mode_r ? pix_r : rd_new);
    mc[0] = win_r[1];
    mc[1] = win_r[3];
    mc[2] = win_r[5];
    if (col_r == AW'(1)) begin
      lc = mode_r ? nc : mc;
    end else begin
      lc[0] = win_r[0];
      lc[1] = win_r[2];
      lc[2] = win_r[4];
    end
    rc = mode_r ? mc : nc;
  end

  // line store read address
  always_comb begin
    case (state_r)
      ST_IDLE:  rd_addr = (in_tuser == KIND_PIXEL) ? c_eff : flush_r;
      ST_FMID:  rd_addr = (flush_r == '0) ? AW'(1) : flush_r - AW'(1);
      ST_FLEFT: rd_addr = flush_r + AW'(1);
      default:  rd_addr = col_r;
    endcase
  end

  assign mem_we = (state_r == ST_PIX);

  sobth_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_old  (rd_old),
    .rd_new  (rd_new),
    .wr_en   (mem_we),
    .wr_addr (col_r),
    .wr_old  (rd_new),
    .wr_new  (pix_r)
  );

  // gradient unit feed
  assign g_start = (state_r == ST_EMIT) && (pa_r || pb_r);
  assign g_l     = pa_r ? cl_r : cm_r;
  assign g_m     = pa_r ? cm_r : cn_r;
  assign g_r     = pa_r ? cn_r : cr_r;

  sobth_grad u_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (g_start),
    .col_l     (g_l),
    .col_m     (g_m),
    .col_r     (g_r),
    .threshold (thr_r),
    .done      (g_done),
    .res       (g_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == KIND_PIXEL) state_nxt = ST_PIX;
          else if (!skip_flush)       state_nxt = ST_FMID;
        end
      end
      ST_PIX:    state_nxt = ST_EMIT;
      ST_FMID:   state_nxt = ST_FLEFT;
      ST_FLEFT:  state_nxt = ST_FRIGHT;
      ST_FRIGHT: state_nxt = ST_EMIT;
      ST_EMIT:   state_nxt = (pa_r || pb_r) ? ST_CALC : ST_IDLE;
      ST_CALC:   if (g_done) state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_tready) state_nxt = ST_EMIT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // counters, window and pending results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= 2'd0;
      flush_r <= '0;
      pa_r    <= 1'b0;
      pb_r    <= 1'b0;
      for (int i = 0; i < 6; i++) win_r[i] <= 8'd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == KIND_PIXEL) && (flush_r != '0)) begin
            col_r   <= '0;
            row_r   <= 2'd0;
            flush_r <= '0;
          end
        end
        ST_PIX: begin
          pa_r <= (row_r != 2'd0) && (col_r != '0);
          pb_r <= (row_r != 2'd0) && c_last;
          if (row_r != 2'd0) begin
            win_r[0] <= win_r[1];
            win_r[1] <= nc[0];
            win_r[2] <= win_r[3];
            win_r[3] <= nc[1];
            win_r[4] <= win_r[5];
            win_r[5] <= nc[2];
          end
          if (c_last) begin
            col_r <= '0;
            if (row_r != 2'd2) row_r <= row_r + 2'd1;
          end else begin
            col_r <= col_r + AW'(1);
          end
        end
        ST_FRIGHT: begin
          pa_r <= 1'b1;
          pb_r <= 1'b0;
          if (k_last) begin
            flush_r <= '0;
            col_r   <= '0;
            row_r   <= 2'd0;
          end else begin
            flush_r <= flush_r + AW'(1);
          end
        end
        ST_EMIT: begin
          if (pa_r) pa_r <= 1'b0;
          else      pb_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        pix_r  <= in_tdata;
        kind_r <= in_tuser;
      end
      ST_PIX: begin
        cl_r   <= lc;
        cm_r   <= mc;
        cn_r   <= nc;
        cr_r   <= rc;
        last_r <= 1'b0;
      end
      ST_FMID: cm_r <= sc;
      ST_FLEFT: begin
        cl_r    <= ((flush_r == '0) && !mode_r) ? cm_r : sc;
        flast_r <= k_last;
      end
      ST_FRIGHT: begin
        cn_r   <= flast_r ? (mode_r ? cl_r : cm_r) : sc;
        last_r <= flast_r && (kind_r == KIND_FLUSH);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_CALC) && g_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_CALC) && g_done) begin
      out_res_r  <= g_res;
      out_last_r <= last_r && !pb_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.magnitude, out_res_r.grad_y,
                       out_res_r.grad_x, out_res_r.edge_pixel};
  assign out_tlast  = out_last_r;
endmodule

### hw/rtl/sobth_checker.sv
`include "assert_macros.svh"

module sobth_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  // a stalled result keeps its payload
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // no new request taken while a result is pending
  `ASSERT_CLK(a_no_overlap, clk, rst_n, in_tready |-> !out_tvalid, "input ready while result pending")

  // no result straight after a request is taken
  `ASSERT_CLK(a_no_early_result, clk, rst_n, in_tvalid && in_tready |=> !out_tvalid, "result right after accept")

  // edge pixel is black or white and magnitude in range
  `ASSERT_CLK(a_result_range, clk, rst_n, out_tvalid |-> (out_tdata[7:0] == 8'd0 || out_tdata[7:0] == 8'd255) && out_tdata[34:26] <= 9'd360, "result out of range")

  // nothing valid straight after reset
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "result valid after reset")
endmodule

bind sobel_edge_threshold sobth_checker u_sobth_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
